### hw/rtl/gwm_pkg.sv
package gwm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    FN_NEW     = 2'd0,
    FN_APPEND  = 2'd1,
    FN_SUBJECT = 2'd2,
    FN_FINISH  = 2'd3
  } func_t;

  // Decoded request for the processing stage.
  typedef struct packed {
    logic go;
    logic clr;
    logic app;
    logic sub;
    logic fin;
  } ctl_t;

  function automatic logic [7:0] fold_ch(input logic [7:0] c, input logic cs);
    logic [7:0] r;
    r = c;
    if (!cs && (c >= CH_UC_A) && (c <= CH_UC_Z)) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

### hw/rtl/gwm_pattern_store.sv
module gwm_pattern_store #(
  parameter int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1),
  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gwm_pkg::ctl_t          ctl,
  input  logic [7:0]             ch,
  input  logic                   case_sensitive,
  output logic [PATTERN_MAX-1:0] vld,
  output logic [PATTERN_MAX-1:0] star,
  output logic [PATTERN_MAX-1:0] hit,
  output logic [PATTERN_MAX-1:0] vld_nxt,
  output logic [PATTERN_MAX-1:0] star_nxt,
  output logic [LW-1:0]          len,
  output logic                   ovf
);

  localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

  logic [7:0]             pat_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] vld_r;
  logic [PATTERN_MAX-1:0] star_r;
  logic [PATTERN_MAX-1:0] any_r;
  logic [PATTERN_MAX-1:0] any_nxt;
  logic [LW-1:0]          len_r;
  logic [LW-1:0]          len_nxt;
  logic                   ovf_r;
  logic                   ovf_nxt;
  logic                   full;
  logic                   wr_en;
  logic [7:0]             ch_fold;

  assign full  = (len_r == LEN_MAX);
  assign wr_en = ctl.go && ctl.app && !full;

  always_comb begin
    vld_nxt  = vld_r;
    star_nxt = star_r;
    any_nxt  = any_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    if (ctl.go && ctl.clr) begin
      vld_nxt = '0;
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (ctl.go && ctl.app) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LW'(1);
        for (int i = 0; i < PATTERN_MAX; i++) begin
          if (len_r == LW'(i)) begin
            vld_nxt[i]  = 1'b1;
            star_nxt[i] = (ch == gwm_pkg::CH_STAR);
            any_nxt[i]  = (ch == gwm_pkg::CH_ANY);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Entry contents carry no reset; the valid mask hides unwritten entries.
  always_ff @(posedge clk) begin
    star_r <= star_nxt;
    any_r  <= any_nxt;
    if (wr_en) begin
      pat_r[len_r[IW-1:0]] <= ch;
    end
  end

  assign ch_fold = gwm_pkg::fold_ch(ch, case_sensitive);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i] = any_r[i] || (gwm_pkg::fold_ch(pat_r[i], case_sensitive) == ch_fold);
    end
  end

  assign vld  = vld_r;
  assign star = star_r;
  assign len  = len_r;
  assign ovf  = ovf_r;

endmodule

### hw/rtl/gwm_active.sv
module gwm_active #(
  parameter int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gwm_pkg::ctl_t          ctl,
  input  logic [PATTERN_MAX-1:0] vld,
  input  logic [PATTERN_MAX-1:0] star,
  input  logic [PATTERN_MAX-1:0] hit,
  input  logic [PATTERN_MAX-1:0] vld_nxt,
  input  logic [PATTERN_MAX-1:0] star_nxt,
  input  logic [LW-1:0]          len,
  output logic                   act_at_len
);

  localparam int unsigned AW = PATTERN_MAX + 1;

  logic [AW-1:0]          act_r;
  logic [AW-1:0]          act_nxt;
  logic [PATTERN_MAX-1:0] live;
  logic [PATTERN_MAX-1:0] stay;
  logic [PATTERN_MAX-1:0] adv;
  logic [AW-1:0]          base;
  logic [AW-1:0]          prop;
  logic [AW-1:0]          sum;

  // One subject byte: a live star holds its position, a live literal or
  // '?' that matches moves one position on.
  assign live = act_r[PATTERN_MAX-1:0] & vld;
  assign stay = live & star;
  assign adv  = live & ~star & hit;

  assign base = ctl.sub ? ({1'b0, stay} | {adv, 1'b0}) : AW'(1);

  // Activity flows forward across runs of stars. The carry of
  // (base & prop) + prop ripples through each run that holds an active
  // position, so the XOR with prop marks that run from the active position on and the position past it.
  assign prop    = {1'b0, vld_nxt & star_nxt};
  assign sum     = (base & prop) + prop;
  assign act_nxt = base | (sum ^ prop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= AW'(1);
    end else if (ctl.go) begin
      act_r <= act_nxt;
    end
  end

  assign act_at_len = act_r[len];

endmodule

### hw/rtl/glob_wildcard_match_unit.sv
// Glob matcher: '*' matches any run of bytes, '?' matches exactly one byte.
// Requests come on in_valid/in_stall with in_func and in_ch. A new-pattern
// request clears the pattern, append requests add one pattern byte each,
// subject requests stream the subject one byte each, and a finish request
// returns one result on out_valid/out_stall (out_matched, out_overflow) and
// re-arms for the next subject. Only finish requests give a result.
// cfg_wr_en/cfg_wr_data write case_sensitive (0 folds ASCII letters).
// A finish request is registered in the request stage and its result in the output
// register. Throughput: one request per cycle of any kind while in_stall is low;
// the critical path is the carry chain that spreads activity across runs of
// stars, one add as wide as the pattern store plus one.
// A result waiting in the output register does not block new requests;
// only a finish request that reaches the processing stage while the result
// register is still full and stalled holds the stage, and in_stall follows.
// Reset (rst_n low, synchronous) empties the pattern, clears overflow and
// case_sensitive, and drops any request in flight and any pending result.
// Patterns longer than PATTERN_MAX set overflow and report no match.
module glob_wildcard_match_unit #(
  parameter int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_overflow
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

  logic                   cs_r;
  logic                   s1_valid_r;
  gwm_pkg::func_t         s1_func_r;
  logic [7:0]             s1_ch_r;
  logic                   s1_go;
  logic                   s1_fin;
  gwm_pkg::ctl_t          ctl;
  logic                   in_take;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   out_matched_r;
  logic                   out_overflow_r;
  logic [PATTERN_MAX-1:0] vld;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] vld_nxt;
  logic [PATTERN_MAX-1:0] star_nxt;
  logic [LW-1:0]          len;
  logic                   ovf;
  logic                   act_at_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cs_r <= cfg_wr_data;
    end
  end

  assign s1_fin   = (s1_func_r == gwm_pkg::FN_FINISH);
  assign s1_go    = s1_valid_r && (!s1_fin || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= gwm_pkg::func_t'(in_func);
      s1_ch_r   <= in_ch;
    end
  end

  always_comb begin
    ctl     = '0;
    ctl.go  = s1_go;
    case (s1_func_r)
      gwm_pkg::FN_NEW:     ctl.clr = 1'b1;
      gwm_pkg::FN_APPEND:  ctl.app = 1'b1;
      gwm_pkg::FN_SUBJECT: ctl.sub = 1'b1;
      gwm_pkg::FN_FINISH:  ctl.fin = 1'b1;
      default:             ctl.fin = 1'b1;
    endcase
  end

  gwm_pattern_store #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .ch            (s1_ch_r),
    .case_sensitive(cs_r),
    .vld           (vld),
    .star          (star),
    .hit           (hit),
    .vld_nxt       (vld_nxt),
    .star_nxt      (star_nxt),
    .len           (len),
    .ovf           (ovf)
  );

  gwm_active #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_active (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .vld       (vld),
    .star      (star),
    .hit       (hit),
    .vld_nxt   (vld_nxt),
    .star_nxt  (star_nxt),
    .len       (len),
    .act_at_len(act_at_len)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && ctl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && ctl.fin) begin
      out_matched_r  <= !ovf && act_at_len;
      out_overflow_r <= ovf;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_overflow_r |-> !out_matched_r)
    else $error("overflow result reports a match");

  a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && ctl.fin |=> out_valid_r)
    else $error("finish request left no result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_fin && out_valid_r && out_stall)
    else $error("input stalled without a blocked finish");

  a_new_clears_len: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && ctl.clr |=> (len == '0) && !ovf)
    else $error("new pattern did not clear length and overflow");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && ctl.app && (len == LW'(PATTERN_MAX)) |=> ovf)
    else $error("append without room did not flag overflow");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import gwm_pkg::*;

  localparam int unsigned PAT_MAX = PATTERN_MAX_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int NUM_DIR = 33;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  typedef struct packed {
    func_t      f;
    logic [7:0] ch;
    logic [6:0] reps;
    logic       pin;
    logic       m;
    logic       o;
  } dir_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_HEAVY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = FN_NEW;
  logic [7:0] in_ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_matched;
  logic       out_overflow;

  // Typed-in expectation that travels with the request it belongs to.
  logic pin_en = 1'b0;
  logic pin_m = 1'b0;
  logic pin_o = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glob_wildcard_match_unit #(.PATTERN_MAX(PAT_MAX)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_ch       (in_ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_matched (out_matched),
    .out_overflow(out_overflow)
  );

  // Glob state as the block should hold it.
  logic [7:0]       pat_mem [PAT_MAX];
  int unsigned      pat_len;
  logic [PAT_MAX:0] live_pos;
  logic             pat_ovf;
  logic             case_exact;
  verdict_t         verdicts_due [$];
  int               fail_count = 0;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (!case_exact && c >= CH_UC_A && c <= CH_UC_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

  // A star can match nothing, so activity carries forward across it.
  task automatic spread_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i] && pat_mem[i] == CH_STAR) begin
        live_pos[i + 1] = 1'b1;
      end
    end
  endtask

  task automatic rearm_positions();
    live_pos = '0;
    live_pos[0] = 1'b1;
    spread_stars();
  endtask

  task automatic eat_subject_byte(input logic [7:0] c);
    logic [PAT_MAX:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_mem[i] == CH_STAR) begin
          nxt[i] = 1'b1;
        end else if (pat_mem[i] == CH_ANY || fold_byte(pat_mem[i]) == fold_byte(c)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    live_pos = nxt;
    spread_stars();
  endtask

  task automatic advance_glob(input func_t f, input logic [7:0] c, output logic fin,
                              output verdict_t v);
    fin = 1'b0;
    v = '0;
    case (f)
      FN_NEW: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        rearm_positions();
      end
      FN_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        rearm_positions();
      end
      FN_SUBJECT: begin
        eat_subject_byte(c);
      end
      default: begin
        fin = 1'b1;
        v.matched = !pat_ovf && live_pos[pat_len];
        v.overflow = pat_ovf;
        rearm_positions();
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor_blk
    logic     fin;
    verdict_t v;
    verdict_t want;
    if (!rst_n) begin
      pat_len = 0;
      pat_ovf = 1'b0;
      case_exact = 1'b0;
      rearm_positions();
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case_exact = cfg_wr_data;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (verdicts_due.size() == 0) begin
          $error("result arrived with no finish request waiting");
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, out_matched);
            fail_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        advance_glob(func_t'(in_func), in_ch, fin, v);
        if (fin) begin
          verdicts_due.push_back(pin_en ? verdict_t'{pin_m, pin_o} : v);
        end
      end
    end
  end

  // Receiver: stretches of free flow, coin-flip stalls and heavy stalls.
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_COIN: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  dir_row_t dir_rows [NUM_DIR] = '{
    // Empty pattern after reset: only the empty subject matches.
    '{FN_FINISH,  8'h00, 1,  1, 1, 0},
    '{FN_SUBJECT, 8'h00, 1,  0, 0, 0},
    '{FN_FINISH,  8'hFF, 1,  1, 0, 0},
    '{FN_NEW,     8'hFF, 1,  0, 0, 0},
    '{FN_APPEND,  8'h41, 1,  0, 0, 0},
    '{FN_APPEND,  CH_ANY, 1, 0, 0, 0},
    '{FN_APPEND,  CH_STAR, 1, 0, 0, 0},
    '{FN_APPEND,  8'hFF, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h61, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h00, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h78, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'hFF, 1,  0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h41, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h2A, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'hFF, 1,  0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  0, 0, 0},
    // An append after subject bytes throws those bytes away.
    '{FN_SUBJECT, 8'h62, 1,  0, 0, 0},
    '{FN_APPEND,  CH_STAR, 1, 0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  0, 0, 0},
    // Fill the store exactly, then push one byte past it.
    '{FN_NEW,     8'h00, 1,  0, 0, 0},
    '{FN_APPEND,  CH_STAR, 64, 0, 0, 0},
    '{FN_SUBJECT, 8'h55, 3,  0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  1, 1, 0},
    '{FN_APPEND,  8'h71, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h71, 1,  0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  1, 0, 1},
    '{FN_NEW,     8'h00, 1,  0, 0, 0},
    // A question mark right after a star still matches any byte.
    '{FN_APPEND,  CH_STAR, 1, 0, 0, 0},
    '{FN_APPEND,  CH_ANY, 1, 0, 0, 0},
    '{FN_SUBJECT, 8'h61, 1,  0, 0, 0},
    '{FN_SUBJECT, 8'h62, 1,  0, 0, 0},
    '{FN_FINISH,  8'h00, 1,  0, 0, 0}
  };

  logic [7:0] drv_pat [$];
  logic [7:0] subj_buf [$];
  int         burst_left = 0;
  int         items_sent = 0;

  task automatic send_req(input func_t f, input logic [7:0] c, input logic pin,
                          input logic m, input logic o);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      in_func <= 2'($urandom_range(0, 3));
      in_ch <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_ch <= c;
    pin_en <= pin;
    pin_m <= m;
    pin_o <= o;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (f == FN_NEW) begin
      drv_pat.delete();
    end else if (f == FN_APPEND && drv_pat.size() < PAT_MAX) begin
      drv_pat.push_back(c);
    end
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
      8, 9, 10: return ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h42;
      11, 12, 13: return CH_STAR;
      14, 15, 16: return CH_ANY;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Most subjects are derived from the pattern so that matches are common;
  // some are then damaged by one byte, some are plain noise.
  task automatic build_subject();
    int idx;
    logic [7:0] p;
    subj_buf.delete();
    foreach (drv_pat[j]) begin
      p = drv_pat[j];
      if (p == CH_STAR) begin
        repeat ($urandom_range(0, 3)) subj_buf.push_back(pick_char());
      end else if (p == CH_ANY) begin
        subj_buf.push_back(8'($urandom_range(0, 255)));
      end else if (((p | 8'h20) >= 8'h61) && ((p | 8'h20) <= 8'h7A)
                   && $urandom_range(0, 2) == 0) begin
        subj_buf.push_back(p ^ 8'h20);
      end else begin
        subj_buf.push_back(p);
      end
    end
    idx = $urandom_range(0, subj_buf.size());
    case ($urandom_range(0, 9))
      0, 1: begin
        subj_buf.delete();
        repeat ($urandom_range(0, 6)) subj_buf.push_back(pick_char());
      end
      2: if (subj_buf.size() > 0) subj_buf[idx % subj_buf.size()] = 8'($urandom_range(0, 255));
      3: if (subj_buf.size() > 0) subj_buf.delete(idx % subj_buf.size());
      4: subj_buf.insert(idx, pick_char());
      default: ;
    endcase
  endtask

  task automatic run_glob_sequence();
    int r;
    int plen;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      plen = $urandom_range(0, 8);
    end else if (r < 95) begin
      plen = $urandom_range(9, 40);
    end else begin
      plen = $urandom_range(60, 70);
    end
    // Now and then keep the old pattern and extend it.
    if ($urandom_range(0, 9) != 0) begin
      send_req(FN_NEW, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    end
    repeat (plen) send_req(FN_APPEND, pick_char(), 1'b0, 1'b0, 1'b0);
    repeat ($urandom_range(1, 4)) begin
      build_subject();
      foreach (subj_buf[j]) send_req(FN_SUBJECT, subj_buf[j], 1'b0, 1'b0, 1'b0);
      send_req(FN_FINISH, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    end
  endtask

  // The block may still be working on a request that gives no result, so
  // the bench waits on past the last result before the register changes.
  task automatic set_case_mode(input logic v);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int goal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_req(dir_rows[r].f, dir_rows[r].ch, dir_rows[r].pin, dir_rows[r].m,
                 dir_rows[r].o);
      end
    end
    // The pattern and any partial subject carry over each register change.
    for (int ph = 0; ph < 4; ph++) begin
      set_case_mode(ph % 2 == 0);
      goal = items_sent + 400;
      while (items_sent < goal) begin
        if ($urandom_range(0, 6) != 0) begin
          run_glob_sequence();
        end else begin
          send_req(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'b0, 1'b0, 1'b0);
        end
      end
    end
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_pattern_store.sv
hw/rtl/gwm_active.sv
hw/rtl/glob_wildcard_match_unit.sv
verif/tb_top.sv
